>>> design/r40cc_pkg.sv
// ----------------------------------------------------------------------------
// Radix-40 callsign codec package
// Shared types, constants and character mapping functions for the codec.
// ----------------------------------------------------------------------------
`default_nettype none

package r40cc_pkg;

  // Field widths and the widest supported word.
  localparam int CHAR_W    = 8;
  localparam int WORD_W    = 32;
  localparam int DIGIT_W   = 6;
  localparam int MAX_CHARS = 6;

  // Quotient of a word divided by forty fits in this many bits.
  localparam int QUOT_W = 27;

  // Division by five through a reciprocal: q = (x * RECIP5) >> RECIP_SHIFT.
  localparam logic [31:0] RECIP5      = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 34;
  localparam int          PROD_W      = WORD_W - 3 + 32;

  // Alphabet landmarks.
  localparam logic [DIGIT_W-1:0] LETTER_BASE  = 6'd11;
  localparam logic [DIGIT_W-1:0] DIGIT_SPACE  = 6'd10;
  localparam logic [DIGIT_W-1:0] DIGIT_LPAREN = 6'd37;
  localparam logic [DIGIT_W-1:0] DIGIT_RPAREN = 6'd38;
  localparam logic [DIGIT_W-1:0] DIGIT_HYPHEN = 6'd39;

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_LPAREN  = 8'h28;
  localparam logic [CHAR_W-1:0] CHAR_RPAREN  = 8'h29;
  localparam logic [CHAR_W-1:0] CHAR_HYPHEN  = 8'h2D;
  localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

  // Operation requested with an item.
  typedef enum logic {
    ACT_ENCODE = 1'b0,
    ACT_DECODE = 1'b1
  } action_t;

  // Everything one item carries down the row of cells.
  typedef struct packed {
    logic                             valid;
    action_t                          action;
    logic [WORD_W-1:0]                word;
    logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
  } stage_t;

  // Character to base-40 digit; unknown characters give digit zero.
  function automatic logic [DIGIT_W-1:0] char_to_digit(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0]  u;
    logic [DIGIT_W-1:0] d;
    u = c;
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      u = c - CASE_OFFSET;
    end
    d = '0;
    if (u >= CHAR_ZERO && u <= CHAR_NINE) begin
      d = DIGIT_W'(u - CHAR_ZERO);
    end else if (u >= CHAR_UPPER_A && u <= CHAR_UPPER_Z) begin
      d = DIGIT_W'(u - CHAR_UPPER_A) + LETTER_BASE;
    end else if (u == CHAR_SPACE) begin
      d = DIGIT_SPACE;
    end else if (u == CHAR_LPAREN) begin
      d = DIGIT_LPAREN;
    end else if (u == CHAR_RPAREN) begin
      d = DIGIT_RPAREN;
    end else if (u == CHAR_HYPHEN) begin
      d = DIGIT_HYPHEN;
    end
    return d;
  endfunction

  // Base-40 digit back to its character.
  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    c = CHAR_ZERO;
    if (d < DIGIT_SPACE) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else if (d == DIGIT_SPACE) begin
      c = CHAR_SPACE;
    end else if (d < DIGIT_LPAREN) begin
      c = CHAR_UPPER_A + CHAR_W'(d - LETTER_BASE);
    end else if (d == DIGIT_LPAREN) begin
      c = CHAR_LPAREN;
    end else if (d == DIGIT_RPAREN) begin
      c = CHAR_RPAREN;
    end else if (d == DIGIT_HYPHEN) begin
      c = CHAR_HYPHEN;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> design/r40cc_cell.sv
// ----------------------------------------------------------------------------
// Radix-40 codec cell
// Handles one base-40 digit of an item and registers the item for the next
// cell: multiply-accumulate when encoding, divide by forty when decoding.
// ----------------------------------------------------------------------------
`default_nettype none

module r40cc_cell #(
  parameter int CELL_IDX  = 0,
  parameter int NUM_CELLS = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  r40cc_pkg::stage_t stage_i,
  output r40cc_pkg::stage_t stage_o
);
  import r40cc_pkg::*;

  // Encoding consumes characters first to last; decoding produces them
  // last to first, as the least significant digit comes out first.
  localparam int EncSlot = CELL_IDX;
  localparam int DecSlot = NUM_CELLS - 1 - CELL_IDX;

  logic [DIGIT_W-1:0] enc_digit;
  logic [WORD_W-1:0]  enc_word;
  logic [WORD_W-4:0]  dec_part;
  logic [PROD_W-1:0]  dec_prod;
  logic [QUOT_W-1:0]  dec_quot;
  logic [DIGIT_W-1:0] dec_quot40;
  logic [DIGIT_W-1:0] dec_rem;
  stage_t             stage_nxt;
  stage_t             stage_r;

  // Encode: word * 40 + digit, with forty as 32 + 8.
  always_comb begin
    enc_digit = char_to_digit(stage_i.chars[EncSlot]);
    enc_word  = (stage_i.word << 5) + (stage_i.word << 3) + WORD_W'(enc_digit);
  end

  // Decode: word / 40 as (word / 8) / 5 through a reciprocal multiply. The
  // remainder is below forty, so six low bits of the difference suffice.
  always_comb begin
    dec_part   = stage_i.word[WORD_W-1:3];
    dec_prod   = PROD_W'(dec_part) * PROD_W'(RECIP5);
    dec_quot   = dec_prod[RECIP_SHIFT +: QUOT_W];
    dec_quot40 = {dec_quot[0], 5'b0} + {dec_quot[2:0], 3'b0};
    dec_rem    = stage_i.word[DIGIT_W-1:0] - dec_quot40;
  end

  // Select the work for this item's operation.
  always_comb begin
    stage_nxt = stage_i;
    if (stage_i.action == ACT_DECODE) begin
      stage_nxt.word           = WORD_W'(dec_quot);
      stage_nxt.chars[DecSlot] = digit_to_char(dec_rem);
    end else begin
      stage_nxt.word = enc_word;
    end
  end

  // Valid flag is reset; the payload is not.
  always_ff @(posedge clk) begin
    stage_r.action <= stage_nxt.action;
    stage_r.word   <= stage_nxt.word;
    stage_r.chars  <= stage_nxt.chars;
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else begin
      stage_r.valid <= stage_nxt.valid;
    end
  end

  assign stage_o = stage_r;

endmodule

`default_nettype wire

>>> design/radix40_callsign_codec_top.sv
// ----------------------------------------------------------------------------
// Radix-40 callsign codec
// Packs callsign characters into a base-40 word, or unpacks a word back
// into characters, through a row of one-digit cells.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                                  Transfer
//   --------  -------------------------------------  ------------------------
//   command   start, busy, in_action, in_char_0..5,  start high, busy low
//             in_code_in
//   result    out_valid, out_code_out,               out_valid high, one cycle
//             out_char_0..5
//
// One item may be started in every cycle while busy is low. Each result
// passes through every cell of the row, registered once in each, since every
// cell handles one base-40 digit. The receiver cannot stall, so results
// leave in start order with no back-pressure. Synchronous reset empties the
// row, and busy is high only while reset is held.
//
`default_nettype none

module radix40_callsign_codec_top #(
  parameter int CHARS_PER_WORD = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_action,
  input  logic [7:0] in_char_0,
  input  logic [7:0] in_char_1,
  input  logic [7:0] in_char_2,
  input  logic [7:0] in_char_3,
  input  logic [7:0] in_char_4,
  input  logic [7:0] in_char_5,
  input  logic [31:0] in_code_in,
  output logic       out_valid,
  output logic [31:0] out_code_out,
  output logic [7:0] out_char_0,
  output logic [7:0] out_char_1,
  output logic [7:0] out_char_2,
  output logic [7:0] out_char_3,
  output logic [7:0] out_char_4,
  output logic [7:0] out_char_5
);
  import r40cc_pkg::*;

  stage_t stage_w [CHARS_PER_WORD+1];
  stage_t last_w;
  logic   encode_w;

  // The row never stalls; only reset holds commands off.
  assign busy = ~rst_n;

  // Build the item that enters the first cell.
  always_comb begin
    stage_w[0].valid  = start & ~busy;
    stage_w[0].action = action_t'(in_action);
    if (action_t'(in_action) == ACT_DECODE) begin
      stage_w[0].word  = in_code_in;
      stage_w[0].chars = '0;
    end else begin
      stage_w[0].word  = '0;
      stage_w[0].chars = {in_char_5, in_char_4, in_char_3,
                          in_char_2, in_char_1, in_char_0};
    end
  end

  // Row of cells, one per digit.
  for (genvar g = 0; g < CHARS_PER_WORD; g++) begin : g_cell
    r40cc_cell #(
      .CELL_IDX  (g),
      .NUM_CELLS (CHARS_PER_WORD)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .stage_i (stage_w[g]),
      .stage_o (stage_w[g+1])
    );
  end

  // Result: the word when encoding, the characters when decoding.
  assign last_w   = stage_w[CHARS_PER_WORD];
  assign encode_w = (last_w.action == ACT_ENCODE);

  always_comb begin
    out_valid    = last_w.valid;
    out_code_out = encode_w ? last_w.word : '0;
    out_char_0   = encode_w ? '0 : last_w.chars[0];
    out_char_1   = encode_w ? '0 : last_w.chars[1];
    out_char_2   = encode_w ? '0 : last_w.chars[2];
    out_char_3   = encode_w ? '0 : last_w.chars[3];
    out_char_4   = encode_w ? '0 : last_w.chars[4];
    out_char_5   = encode_w ? '0 : last_w.chars[5];
  end

endmodule

`default_nettype wire

>>> design/r40cc_checker.sv
// ----------------------------------------------------------------------------
// Radix-40 codec port checker
// Watches the top level's ports for latency, spurious results, result shape and range.
// ----------------------------------------------------------------------------
`default_nettype none

module r40cc_checker #(
  parameter int CHARS_PER_WORD = 6
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [31:0] out_code_out,
  input logic [7:0]  out_char_0,
  input logic [7:0]  out_char_1,
  input logic [7:0]  out_char_2,
  input logic [7:0]  out_char_3,
  input logic [7:0]  out_char_4,
  input logic [7:0]  out_char_5
);
  import r40cc_pkg::*;

  localparam longint CodeLimit = 64'd40 ** CHARS_PER_WORD;

  logic cmd_xfer;
  logic chars_zero;

  assign cmd_xfer   = start & ~busy;
  assign chars_zero = (out_char_0 == '0) && (out_char_1 == '0) && (out_char_2 == '0) &&
                      (out_char_3 == '0) && (out_char_4 == '0) && (out_char_5 == '0);

  // Every command transfer yields a result after a fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_xfer |-> ##CHARS_PER_WORD out_valid)
    else $error("result missing after command transfer");

  // No result appears without a command transfer before it.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(cmd_xfer, CHARS_PER_WORD))
    else $error("result without a matching command transfer");

  // A non-zero packed word comes from an encode, so no characters go with it.
  a_encode_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_code_out != '0) |-> chars_zero)
    else $error("encode result carries characters");

  // A packed word never reaches forty to the power of the word length.
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (64'(out_code_out) < CodeLimit))
    else $error("packed word out of range");

endmodule

bind radix40_callsign_codec_top r40cc_checker #(
  .CHARS_PER_WORD (CHARS_PER_WORD)
) u_r40cc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_code_out (out_code_out),
  .out_char_0   (out_char_0),
  .out_char_1   (out_char_1),
  .out_char_2   (out_char_2),
  .out_char_3   (out_char_3),
  .out_char_4   (out_char_4),
  .out_char_5   (out_char_5)
);

`default_nettype wire
